// File: rtl/core/pct_pkg.sv
`timescale 1ns / 1ps

package pct_pkg;

	localparam int PIN_COUNT        = 24;
	localparam int RASTERS_PER_BAND = 29;
	localparam int ROW_W            = $clog2(PIN_COUNT);
	localparam int CNT_W            = $clog2(RASTERS_PER_BAND);
	localparam int PHASE_W          = 3;

	localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd4;
	localparam logic [CNT_W-1:0]   RASTER_LAST = CNT_W'(RASTERS_PER_BAND - 1);
	localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(PIN_COUNT - 1);

	typedef logic [PIN_COUNT-1:0][7:0] pin_bank_t;

	typedef struct packed {
		logic      valid;
		pin_bank_t rows;
	} col_push_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             first;
	} row_sel_t;

	// Rows k with k mod 5 == phase take two rasters, so every five rows take six rasters.
	function automatic row_sel_t map_row(input logic [PHASE_W-1:0] phase,
			input logic [CNT_W-1:0] r);
		logic [2:0] q;
		logic [5:0] base;
		logic [2:0] m;
		logic [2:0] off;
		logic [5:0] row;
		row_sel_t   sel;
		if (r >= CNT_W'(24))
			q = 3'd4;
		else if (r >= CNT_W'(18))
			q = 3'd3;
		else if (r >= CNT_W'(12))
			q = 3'd2;
		else if (r >= CNT_W'(6))
			q = 3'd1;
		else
			q = 3'd0;
		base = 6'({3'd0, q} * 6'd6);
		m    = 3'(6'({1'b0, r}) - base);
		off  = (m <= phase) ? m : 3'(m - 3'd1);
		row  = 6'(6'({3'd0, q} * 6'd5) + 6'({3'd0, off}));
		if (row >= 6'(PIN_COUNT)) begin
			sel.row   = ROW_LAST;
			sel.first = 1'b0;
		end else begin
			sel.row   = row[ROW_W-1:0];
			sel.first = (m != 3'(phase + 3'd1));
		end
		return sel;
	endfunction

endpackage

// File: rtl/core/pct_front.sv
`timescale 1ns / 1ps

module pct_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          raster_byte,
	input  logic                page_start,
	input  logic                band_end,
	output pct_pkg::col_push_t  col_push
);
	import pct_pkg::*;

	pin_bank_t          rows_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [PHASE_W-1:0] phase_eff;
	logic [CNT_W-1:0]   cnt_eff;
	row_sel_t           sel;
	logic [7:0]         row_val;
	pin_bank_t          rows_next;
	logic               col_done;

	always_comb begin
		phase_eff = page_start ? '0 : phase_q;
		cnt_eff   = page_start ? '0 : cnt_q;
		sel       = map_row(phase_eff, cnt_eff);
		row_val   = sel.first ? raster_byte : (rows_q[sel.row] | raster_byte);
		rows_next = rows_q;
		rows_next[sel.row] = row_val;
		col_done  = (cnt_eff == RASTER_LAST);
		col_push.valid = accept && col_done;
		col_push.rows  = rows_next;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rows_q <= rows_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			cnt_q <= col_done ? '0 : CNT_W'(cnt_eff + 1'b1);
			if (band_end)
				phase_q <= (phase_eff >= PHASE_LAST) ? '0 : PHASE_W'(phase_eff + 1'b1);
			else
				phase_q <= phase_eff;
		end
	end

endmodule

// File: rtl/core/pct_colq.sv
`timescale 1ns / 1ps

module pct_colq #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pct_pkg::col_push_t col_push,
	output logic               full,
	output logic               head_valid,
	output pct_pkg::pin_bank_t head_rows,
	input  logic               head_pop
);
	import pct_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pin_bank_t        store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rows  = store_q[rd_ptr_q];
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (col_push.valid)
			store_q[wr_ptr_q] <= col_push.rows;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (col_push.valid)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			case ({col_push.valid, do_pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		col_push.valid |-> !full)
		else $error("column pushed into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("column queue count overflow");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("column queue pointers out of step with count");

endmodule

// File: rtl/core/pct_back.sv
`timescale 1ns / 1ps

module pct_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  pct_pkg::pin_bank_t head_rows,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         head_byte,
	output logic               last_of_column
);
	import pct_pkg::*;

	logic [2:0] pix_q;
	logic [1:0] grp_q;
	logic       xfer;

	assign empty          = !head_valid;
	assign xfer           = pop && head_valid;
	assign last_of_column = (pix_q == 3'd7) && (grp_q == 2'd2);
	assign head_pop       = xfer && last_of_column;

	always_comb begin
		for (int b = 0; b < 8; b++)
			head_byte[7-b] = head_rows[ROW_W'({grp_q, 3'(b)})][3'd7 - pix_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			grp_q <= '0;
		end else if (xfer) begin
			if (grp_q == 2'd2) begin
				grp_q <= '0;
				pix_q <= 3'(pix_q + 1'b1);
			end else begin
				grp_q <= 2'(grp_q + 1'b1);
			end
		end
	end

endmodule

// File: rtl/core/print_head_column_transposer.sv
`timescale 1ns / 1ps

// Takes one raster byte per cycle (push/full) and, on the 29th byte of a column, hands the
// condensed 24-row column to a back end that gives out 24 head bytes, one per cycle
// (empty/pop), three per pixel from the leftmost. A column queue of QUEUE_DEPTH entries
// sits between the two, so the next column loads while the last one drains; full is high
// while the queue holds QUEUE_DEPTH columns not yet fully popped, which stalls loading.
// A column therefore takes 29 input bytes and yields 24 head bytes.
module print_head_column_transposer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] raster_byte,
	input  logic       page_start,
	input  logic       band_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] head_byte,
	output logic       last_of_column
);
	import pct_pkg::*;

	col_push_t col_push;
	logic      accept;
	logic      head_valid;
	pin_bank_t head_rows;
	logic      head_pop;

	assign accept = push && !full;

	pct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.raster_byte (raster_byte),
		.page_start  (page_start),
		.band_end    (band_end),
		.col_push    (col_push)
	);

	pct_colq #(
		.DEPTH (QUEUE_DEPTH)
	) u_colq (
		.clk        (clk),
		.arst_n     (arst_n),
		.col_push   (col_push),
		.full       (full),
		.head_valid (head_valid),
		.head_rows  (head_rows),
		.head_pop   (head_pop)
	);

	pct_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_rows      (head_rows),
		.head_pop       (head_pop),
		.empty          (empty),
		.pop            (pop),
		.head_byte      (head_byte),
		.last_of_column (last_of_column)
	);

endmodule
